### rtl/tlbpm_pkg.sv
// Shared constants for the three-list buffer pool manager.
package tlbpm_pkg;

    localparam int NODES_DEF = 64;

    localparam int NODE_W   = 6;
    localparam int SEL_W    = 2;
    localparam int STATUS_W = 2;
    localparam int LISTS    = 3;

    localparam logic [SEL_W-1:0] SEL_DATA    = 2'd0;
    localparam logic [SEL_W-1:0] SEL_RAW     = 2'd1;
    localparam logic [SEL_W-1:0] SEL_READY   = 2'd2;
    localparam logic [SEL_W-1:0] SEL_INVALID = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

endpackage

### rtl/tlbpm_ram.sv
// Generic simple dual-port RAM with registered read.
module tlbpm_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/three_list_buffer_pool_manager_core.sv
// Top level of the three-list buffer pool manager: free, data and raw-data FIFO lists.
//
// Takes one push or pop request per clock cycle unless a result waits untaken; each
// result appears in the output register on the cycle after its request is accepted and
// is held until taken. The next pointers of all nodes live in one link RAM with a
// registered read port; a pop reads the successor of the new head, and that read data is
// forwarded so pops on the same list can follow each other in consecutive cycles. After
// reset a fill pass writes the link RAM so that node i points to node i+1 (the last node
// to node 0); no request is accepted during that pass.
module three_list_buffer_pool_manager_core #(
    parameter int NODES = tlbpm_pkg::NODES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_mode,
    input  logic [tlbpm_pkg::SEL_W-1:0]       i_queue_select,
    input  logic [tlbpm_pkg::NODE_W-1:0]      i_node_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tlbpm_pkg::NODE_W-1:0]      o_popped_node,
    output logic                              o_node_valid,
    output logic [tlbpm_pkg::STATUS_W-1:0]    o_status,
    output logic                              o_data_empty,
    output logic                              o_raw_empty,
    output logic                              o_ready_empty
);

    localparam int AW    = $clog2(NODES);
    localparam int PW    = (AW > tlbpm_pkg::NODE_W) ? AW : tlbpm_pkg::NODE_W;
    localparam int IDXS  = 1 << tlbpm_pkg::NODE_W;
    localparam int LISTS = tlbpm_pkg::LISTS;

    logic [AW-1:0] w_mod_tab [IDXS];

    for (genvar v = 0; v < IDXS; v++) begin : g_mod
        assign w_mod_tab[v] = AW'(v % NODES);
    end

    logic          r_init;
    logic [AW-1:0] r_init_cnt;
    logic [AW-1:0] r_head     [LISTS];
    logic [AW-1:0] r_tail     [LISTS];
    logic [AW-1:0] r_hnext    [LISTS];
    logic          r_nonempty [LISTS];
    logic          r_pend;
    logic [tlbpm_pkg::SEL_W-1:0] r_pend_list;

    logic          r_out_valid;
    logic [tlbpm_pkg::NODE_W-1:0]   r_popped;
    logic          r_node_valid;
    logic [tlbpm_pkg::STATUS_W-1:0] r_status;
    logic          r_data_empty;
    logic          r_raw_empty;
    logic          r_ready_empty;

    logic [AW-1:0] n_head     [LISTS];
    logic [AW-1:0] n_tail     [LISTS];
    logic [AW-1:0] n_hnext    [LISTS];
    logic          n_nonempty [LISTS];

    logic [AW-1:0] w_hnext_eff [LISTS];
    logic [AW-1:0] w_rdata;
    logic [AW-1:0] w_node;
    logic [AW-1:0] w_init_next;
    logic [PW-1:0] w_taken_ext;
    logic [tlbpm_pkg::SEL_W-1:0] w_idx;
    logic          w_accept;
    logic          w_sel_ok;
    logic          w_push;
    logic          w_push_link;
    logic          w_pop_ok;
    logic          w_single;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_wdata;
    logic          w_re;
    logic [tlbpm_pkg::STATUS_W-1:0] w_status;

    assign o_ready  = !r_init && (!r_out_valid || i_ready);
    assign w_accept = i_valid && o_ready;
    assign w_sel_ok = (i_queue_select != tlbpm_pkg::SEL_INVALID);
    assign w_idx    = w_sel_ok ? i_queue_select : tlbpm_pkg::SEL_DATA;
    assign w_node   = w_mod_tab[i_node_index];

    always_comb begin
        for (int l = 0; l < LISTS; l++) begin
            w_hnext_eff[l] = (r_pend && (r_pend_list == tlbpm_pkg::SEL_W'(l)))
                           ? w_rdata : r_hnext[l];
        end
    end

    assign w_push      = w_accept && w_sel_ok && i_mode;
    assign w_push_link = w_push && r_nonempty[w_idx];
    assign w_pop_ok    = w_accept && w_sel_ok && !i_mode && r_nonempty[w_idx];
    assign w_single    = (r_head[w_idx] == r_tail[w_idx]);
    assign w_init_next = (r_init_cnt == AW'(NODES - 1)) ? '0 : r_init_cnt + AW'(1);

    assign w_we    = r_init || w_push_link;
    assign w_waddr = r_init ? r_init_cnt : r_tail[w_idx];
    assign w_wdata = r_init ? w_init_next : w_node;
    assign w_re    = w_pop_ok && !w_single;

    tlbpm_ram #(
        .WIDTH(AW),
        .DEPTH(NODES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_hnext_eff[w_idx]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        for (int l = 0; l < LISTS; l++) begin
            n_head[l]     = r_head[l];
            n_tail[l]     = r_tail[l];
            n_nonempty[l] = r_nonempty[l];
            n_hnext[l]    = w_hnext_eff[l];
            if (w_push_link && (r_head[l] == r_tail[w_idx])) begin
                n_hnext[l] = w_node;
            end
        end
        if (w_push) begin
            if (!r_nonempty[w_idx]) begin
                n_head[w_idx]     = w_node;
                n_nonempty[w_idx] = 1'b1;
            end
            n_tail[w_idx] = w_node;
        end else if (w_pop_ok) begin
            if (w_single) begin
                n_nonempty[w_idx] = 1'b0;
            end else begin
                n_head[w_idx] = w_hnext_eff[w_idx];
            end
        end
    end

    always_comb begin
        if (!w_sel_ok) begin
            w_status = tlbpm_pkg::ST_INVALID;
        end else if (!i_mode && !r_nonempty[w_idx]) begin
            w_status = tlbpm_pkg::ST_EMPTY;
        end else begin
            w_status = tlbpm_pkg::ST_OK;
        end
    end

    assign w_taken_ext = PW'(r_head[w_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b1;
            r_init_cnt  <= '0;
            r_pend      <= 1'b0;
            r_pend_list <= tlbpm_pkg::SEL_DATA;
            r_out_valid <= 1'b0;
            for (int l = 0; l < LISTS; l++) begin
                r_head[l]     <= '0;
                r_tail[l]     <= (l == int'(tlbpm_pkg::SEL_READY)) ? AW'(NODES - 1) : '0;
                r_hnext[l]    <= (l == int'(tlbpm_pkg::SEL_READY)) ? AW'(1) : '0;
                r_nonempty[l] <= (l == int'(tlbpm_pkg::SEL_READY));
            end
        end else begin
            if (r_init) begin
                r_init_cnt <= w_init_next;
                if (r_init_cnt == AW'(NODES - 1)) begin
                    r_init <= 1'b0;
                end
            end
            r_pend      <= w_re;
            r_pend_list <= w_idx;
            for (int l = 0; l < LISTS; l++) begin
                r_head[l]     <= n_head[l];
                r_tail[l]     <= n_tail[l];
                r_hnext[l]    <= n_hnext[l];
                r_nonempty[l] <= n_nonempty[l];
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped      <= w_pop_ok ? w_taken_ext[tlbpm_pkg::NODE_W-1:0] : '0;
            r_node_valid  <= w_pop_ok;
            r_status      <= w_status;
            r_data_empty  <= !n_nonempty[tlbpm_pkg::SEL_DATA];
            r_raw_empty   <= !n_nonempty[tlbpm_pkg::SEL_RAW];
            r_ready_empty <= !n_nonempty[tlbpm_pkg::SEL_READY];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_popped_node = r_popped;
    assign o_node_valid  = r_node_valid;
    assign o_status      = r_status;
    assign o_data_empty  = r_data_empty;
    assign o_raw_empty   = r_raw_empty;
    assign o_ready_empty = r_ready_empty;

`ifndef ASSERT_OFF
    a_no_accept_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_ready)
        else $error("item accepted during link fill");

    a_fill_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_init && (r_init_cnt == AW'(NODES - 1))) |=> !r_init)
        else $error("link fill did not end");

    a_pend_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(w_pop_ok))
        else $error("link read pending without a pop");

    a_pop_gives_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_sel_ok && !i_mode && r_nonempty[w_idx])
        |=> (o_valid && o_node_valid && (o_status == tlbpm_pkg::ST_OK)))
        else $error("pop of nonempty list gave no node");
`endif

endmodule

### tb/pool_list_monitor.sv
// Request/result monitor for the buffer pool manager: tracks the three lists and scores results.
`timescale 1ns / 100ps

module pool_list_monitor #(
    parameter int NODES = tlbpm_pkg::NODES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  logic                              i_req_ready,
    input  logic                              i_mode,
    input  logic [tlbpm_pkg::SEL_W-1:0]       i_queue_select,
    input  logic [tlbpm_pkg::NODE_W-1:0]      i_node_index,
    input  logic                              i_rsp_valid,
    input  logic                              i_rsp_ready,
    input  logic [tlbpm_pkg::NODE_W-1:0]      i_popped_node,
    input  logic                              i_node_valid,
    input  logic [tlbpm_pkg::STATUS_W-1:0]    i_status,
    input  logic                              i_data_empty,
    input  logic                              i_raw_empty,
    input  logic                              i_ready_empty,
    output int                                o_pending,
    output int                                o_mismatches
);

    typedef struct packed {
        logic [tlbpm_pkg::NODE_W-1:0]   node;
        logic                           node_valid;
        logic [tlbpm_pkg::STATUS_W-1:0] status;
        logic                           data_empty;
        logic                           raw_empty;
        logic                           ready_empty;
    } t_pool_result;

    logic [tlbpm_pkg::NODE_W-1:0] link_next [NODES];
    logic [tlbpm_pkg::NODE_W-1:0] head_of [tlbpm_pkg::LISTS];
    logic [tlbpm_pkg::NODE_W-1:0] tail_of [tlbpm_pkg::LISTS];
    logic                         occupied [tlbpm_pkg::LISTS];
    t_pool_result                 owed_q [$];
    int                           mismatches = 0;
    int                           seen = 0;

    assign o_mismatches = mismatches;

    function automatic t_pool_result apply_request(logic push,
                                                   logic [tlbpm_pkg::SEL_W-1:0] sel,
                                                   logic [tlbpm_pkg::NODE_W-1:0] idx);
        t_pool_result                 r;
        logic [tlbpm_pkg::NODE_W-1:0] node;
        node = tlbpm_pkg::NODE_W'(int'(idx) % NODES);
        r = '0;
        if (sel > tlbpm_pkg::SEL_READY) begin
            r.status = tlbpm_pkg::ST_INVALID;
        end else if (push) begin
            if (occupied[sel]) begin
                link_next[tail_of[sel]] = node;
            end else begin
                head_of[sel]  = node;
                occupied[sel] = 1'b1;
            end
            tail_of[sel] = node;
            r.status = tlbpm_pkg::ST_OK;
        end else if (!occupied[sel]) begin
            r.status = tlbpm_pkg::ST_EMPTY;
        end else begin
            r.node       = head_of[sel];
            r.node_valid = 1'b1;
            r.status     = tlbpm_pkg::ST_OK;
            if (head_of[sel] == tail_of[sel]) begin
                occupied[sel] = 1'b0;
            end else begin
                head_of[sel] = link_next[head_of[sel]];
            end
        end
        r.data_empty  = !occupied[tlbpm_pkg::SEL_DATA];
        r.raw_empty   = !occupied[tlbpm_pkg::SEL_RAW];
        r.ready_empty = !occupied[tlbpm_pkg::SEL_READY];
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("result %0d: %s is %0d, expected %0d", seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_pool_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                link_next[i] = tlbpm_pkg::NODE_W'((i + 1) % NODES);
            end
            for (int l = 0; l < tlbpm_pkg::LISTS; l++) begin
                head_of[l]  = '0;
                tail_of[l]  = '0;
                occupied[l] = 1'b0;
            end
            tail_of[tlbpm_pkg::SEL_READY]  = tlbpm_pkg::NODE_W'(NODES - 1);
            occupied[tlbpm_pkg::SEL_READY] = 1'b1;
            owed_q.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (owed_q.size() == 0) begin
                    note_mismatch("popped_node of a result with no request",
                                  8'(i_popped_node), 'x);
                end else begin
                    want = owed_q.pop_front();
                    if (i_popped_node !== want.node)
                        note_mismatch("popped_node", 8'(i_popped_node), 8'(want.node));
                    if (i_node_valid !== want.node_valid)
                        note_mismatch("node_valid", 8'(i_node_valid), 8'(want.node_valid));
                    if (i_status !== want.status)
                        note_mismatch("status", 8'(i_status), 8'(want.status));
                    if (i_data_empty !== want.data_empty)
                        note_mismatch("data_empty", 8'(i_data_empty), 8'(want.data_empty));
                    if (i_raw_empty !== want.raw_empty)
                        note_mismatch("raw_empty", 8'(i_raw_empty), 8'(want.raw_empty));
                    if (i_ready_empty !== want.ready_empty)
                        note_mismatch("ready_empty", 8'(i_ready_empty), 8'(want.ready_empty));
                end
                seen++;
            end
            if (i_req_valid && i_req_ready) begin
                owed_q.push_back(apply_request(i_mode, i_queue_select, i_node_index));
            end
        end
        o_pending <= owed_q.size();
    end

endmodule

### tb/three_list_buffer_pool_manager_core_tb.sv
// Stimulus and verdict for the three-list buffer pool manager core.
`timescale 1ns / 100ps

module three_list_buffer_pool_manager_core_tb;

    localparam int  LIMIT_CYCLES = 200000;
    localparam int  HOLD_CYCLES  = 150;
    localparam logic OP_POP      = 1'b0;
    localparam logic OP_PUSH     = 1'b1;

    typedef logic [tlbpm_pkg::NODE_W-1:0] t_node;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic                           i_mode = 1'b0;
    logic [tlbpm_pkg::SEL_W-1:0]    i_queue_select = '0;
    t_node                          i_node_index = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    t_node                          o_popped_node;
    logic                           o_node_valid;
    logic [tlbpm_pkg::STATUS_W-1:0] o_status;
    logic                           o_data_empty;
    logic                           o_raw_empty;
    logic                           o_ready_empty;

    int    pending;
    int    mismatches;
    int    hold_requests = 0;
    int    cycle_count = 0;
    bit    burst = 1'b0;
    t_node track_q [tlbpm_pkg::LISTS][$];
    t_node spare_q [$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    three_list_buffer_pool_manager_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_queue_select (i_queue_select),
        .i_node_index   (i_node_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_popped_node  (o_popped_node),
        .o_node_valid   (o_node_valid),
        .o_status       (o_status),
        .o_data_empty   (o_data_empty),
        .o_raw_empty    (o_raw_empty),
        .o_ready_empty  (o_ready_empty)
    );

    pool_list_monitor monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_mode         (i_mode),
        .i_queue_select (i_queue_select),
        .i_node_index   (i_node_index),
        .i_rsp_valid    (o_valid),
        .i_rsp_ready    (i_ready),
        .i_popped_node  (o_popped_node),
        .i_node_valid   (o_node_valid),
        .i_status       (o_status),
        .i_data_empty   (o_data_empty),
        .i_raw_empty    (o_raw_empty),
        .i_ready_empty  (o_ready_empty),
        .o_pending      (pending),
        .o_mismatches   (mismatches)
    );

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic issue(logic push, logic [tlbpm_pkg::SEL_W-1:0] sel, t_node idx);
        int gap;
        int k;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= push;
        i_queue_select <= sel;
        i_node_index   <= idx;
        do @(posedge i_clk); while (!o_ready);
        if (sel != tlbpm_pkg::SEL_INVALID) begin
            if (push) begin
                track_q[sel].push_back(idx);
                for (k = 0; k < spare_q.size(); k++) begin
                    if (spare_q[k] == idx) begin
                        spare_q.delete(k);
                        break;
                    end
                end
            end else if (track_q[sel].size() > 0) begin
                spare_q.push_back(track_q[sel].pop_front());
            end
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int gap;
        int holds_done;
        holds_done = 0;
        forever begin
            if (hold_requests != holds_done) begin
                holds_done++;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = draw_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        int                          n;
        int                          pick;
        int                          k;
        logic [tlbpm_pkg::SEL_W-1:0] sel;

        for (n = 0; n < tlbpm_pkg::NODES_DEF; n++) begin
            track_q[tlbpm_pkg::SEL_READY].push_back(t_node'(n));
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(OP_POP,  tlbpm_pkg::SEL_DATA,    6'd0);
        issue(OP_POP,  tlbpm_pkg::SEL_RAW,     6'd63);
        issue(OP_POP,  tlbpm_pkg::SEL_INVALID, 6'd0);
        issue(OP_PUSH, tlbpm_pkg::SEL_INVALID, 6'd63);
        issue(OP_POP,  tlbpm_pkg::SEL_READY,   6'd0);
        issue(OP_POP,  tlbpm_pkg::SEL_READY,   6'd0);
        issue(OP_POP,  tlbpm_pkg::SEL_READY,   6'd0);
        issue(OP_PUSH, tlbpm_pkg::SEL_DATA,    6'd0);
        issue(OP_PUSH, tlbpm_pkg::SEL_RAW,     6'd1);
        issue(OP_POP,  tlbpm_pkg::SEL_DATA,    6'd0);
        issue(OP_POP,  tlbpm_pkg::SEL_RAW,     6'd0);
        issue(OP_POP,  tlbpm_pkg::SEL_DATA,    6'd0);
        issue(OP_PUSH, tlbpm_pkg::SEL_DATA,    6'd2);
        issue(OP_PUSH, tlbpm_pkg::SEL_DATA,    6'd0);
        issue(OP_PUSH, tlbpm_pkg::SEL_DATA,    6'd1);
        issue(OP_POP,  tlbpm_pkg::SEL_DATA,    6'd0);
        issue(OP_POP,  tlbpm_pkg::SEL_DATA,    6'd0);
        issue(OP_POP,  tlbpm_pkg::SEL_DATA,    6'd0);
        issue(OP_PUSH, tlbpm_pkg::SEL_READY,   6'd1);
        issue(OP_PUSH, tlbpm_pkg::SEL_READY,   6'd0);
        issue(OP_PUSH, tlbpm_pkg::SEL_RAW,     6'd2);
        issue(OP_POP,  tlbpm_pkg::SEL_RAW,     6'd0);
        issue(OP_PUSH, tlbpm_pkg::SEL_READY,   6'd2);

        for (n = 0; n < 700; n++) begin
            if (n % 100 == 0) burst = (n == 300) || ($urandom_range(0, 3) == 0);
            if (n == 200) hold_requests <= hold_requests + 1;
            if (n == 350) wait_drained();
            if (n == 450) begin
                while (track_q[tlbpm_pkg::SEL_READY].size() > 0) begin
                    issue(OP_POP, tlbpm_pkg::SEL_READY, t_node'($urandom));
                end
                issue(OP_POP, tlbpm_pkg::SEL_READY, t_node'($urandom));
            end
            pick = $urandom_range(0, 99);
            sel  = tlbpm_pkg::SEL_W'($urandom_range(0, 2));
            if (pick < 8) begin
                issue(1'($urandom), tlbpm_pkg::SEL_INVALID, t_node'($urandom));
            end else if (pick < 15) begin
                issue(OP_POP, sel, t_node'($urandom));
            end else if (spare_q.size() > 0 && (pick < 58 ||
                         (track_q[tlbpm_pkg::SEL_DATA].size() == 0 &&
                          track_q[tlbpm_pkg::SEL_RAW].size() == 0 &&
                          track_q[tlbpm_pkg::SEL_READY].size() == 0))) begin
                k = $urandom_range(0, spare_q.size() - 1);
                issue(OP_PUSH, sel, spare_q[k]);
            end else begin
                while (track_q[sel].size() == 0) sel = tlbpm_pkg::SEL_W'($urandom_range(0, 2));
                issue(OP_POP, sel, t_node'($urandom));
            end
        end

        burst = 1'b0;
        for (n = 0; n < 48; n++) begin
            issue(1'($urandom), tlbpm_pkg::SEL_W'($urandom), t_node'($urandom));
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
